// ===== sv/nbpe_pkg.sv =====
`timescale 1ns / 1ps

package nbpe_pkg;

  // Width of box sizes, parent budgets and the remaining byte count
  localparam int unsigned SizeWidth = 64;
  typedef logic [SizeWidth-1:0] size_t;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  // Four-character box types, big-endian
  localparam logic [31:0] OuterTypeReset  = 32'h6D6F6F76;  // moov
  localparam logic [31:0] MiddleTypeReset = 32'h75647461;  // udta
  localparam logic [31:0] LeafTypeReset   = 32'h7374656D;  // stem

  localparam size_t HdrLenShort = size_t'(8);
  localparam size_t HdrLenLong  = size_t'(16);
  localparam logic [31:0] ExtSizeMark = 32'd1;

  typedef enum logic [1:0] {
    PhHeader,
    PhExt,
    PhSkip,
    PhPayload
  } phase_e;

  typedef enum logic [2:0] {
    StPayload  = 3'd0,
    StEmpty    = 3'd1,
    StNotStem  = 3'd2,
    StTruncHdr = 3'd3,
    StTruncExt = 3'd4,
    StTruncPay = 3'd5
  } status_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgOuter  = 2'd0,
    CfgMiddle = 2'd1,
    CfgLeaf   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    status_e    status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0] outer_box_type;
    logic [31:0] middle_box_type;
    logic [31:0] leaf_box_type;
  } box_cfg_t;

endpackage

// ===== sv/nbpe_core.sv =====
`timescale 1ns / 1ps

module nbpe_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  nbpe_pkg::in_item_t  item_i,
  input  nbpe_pkg::box_cfg_t  cfg_i,
  output logic                res_valid_o,
  output nbpe_pkg::out_item_t res_o
);
  import nbpe_pkg::*;

  phase_e       phase_q, phase_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [63:0]  shift_q, shift_d;
  logic [31:0]  type_q, type_d;
  logic [1:0]   depth_q, depth_d;
  size_t        budget_q [2];
  size_t        budget_d [2];
  size_t        left_q, left_d;
  logic         done_q, done_d;

  logic [63:0]  shift_nx;
  logic         hdr_last;
  logic         hb_ext;
  logic [63:0]  hb_size64;
  logic [31:0]  hb_type;
  size_t        hb_hdr;
  size_t        hb_size;
  logic         hb_over;
  logic         hb_short;
  logic         top_idx;
  logic         has_parent;
  size_t        top_budget;
  size_t        new_top;
  logic         overrun;
  size_t        rest;
  logic         enter;
  logic         leaf_hit;
  logic         cur_empty;
  size_t        left_nx;
  logic         next_empty;
  logic         res_valid;
  out_item_t    res;

  assign shift_nx   = {shift_q[55:0], item_i.data_byte};
  assign hdr_last   = (cnt_q == 3'd7);
  assign hb_ext     = (phase_q == PhExt);
  assign hb_size64  = hb_ext ? shift_nx : {32'd0, shift_nx[63:32]};
  assign hb_type    = hb_ext ? type_q : shift_nx[31:0];
  assign hb_hdr     = hb_ext ? HdrLenLong : HdrLenShort;
  assign hb_over    = |(hb_size64 >> SizeWidth);
  assign hb_size    = hb_size64[SizeWidth-1:0];
  assign hb_short   = hb_over || (hb_size < hb_hdr);
  assign top_idx    = depth_q[1];
  assign has_parent = (depth_q != 2'd0);
  assign top_budget = budget_q[top_idx];
  assign {overrun, new_top} = {1'b0, top_budget} - {1'b0, hb_size};
  assign rest       = hb_size - hb_hdr;
  assign enter      = ((depth_q == 2'd0) && (hb_type == cfg_i.outer_box_type)) ||
                      ((depth_q == 2'd1) && (hb_type == cfg_i.middle_box_type));
  assign leaf_hit   = (depth_q == 2'd2) && (hb_type == cfg_i.leaf_box_type);
  assign cur_empty  = has_parent && (top_budget == '0);
  assign left_nx    = left_q - size_t'(1);

  always_comb begin
    phase_d          = phase_q;
    cnt_d            = cnt_q;
    shift_d          = shift_q;
    type_d           = type_q;
    depth_d          = depth_q;
    budget_d         = budget_q;
    left_d           = left_q;
    done_d           = done_q;
    res_valid        = 1'b0;
    res.payload_byte = 8'd0;
    res.status       = StPayload;
    res.last_of_run  = 1'b0;
    next_empty       = 1'b0;

    if (go_i) begin
      if (!done_q) begin
        case (phase_q)
          PhHeader, PhExt: begin
            shift_d = shift_nx;
            cnt_d   = cnt_q + 3'd1;
            if (hdr_last) begin
              if (!hb_ext) begin
                type_d = shift_nx[31:0];
              end
              if (!hb_ext && (shift_nx[63:32] == ExtSizeMark)) begin
                phase_d = PhExt;
                cnt_d   = 3'd0;
              end else if (hb_short || (has_parent && overrun)) begin
                res_valid  = 1'b1;
                res.status = StNotStem;
              end else begin
                if (has_parent) begin
                  budget_d[top_idx] = new_top;
                end
                if (enter) begin
                  // Open the box: its payload becomes the new innermost budget
                  budget_d[depth_q[0]] = rest;
                  depth_d = depth_q + 2'd1;
                  phase_d = PhHeader;
                  cnt_d   = 3'd0;
                  if (rest == '0) begin
                    res_valid  = 1'b1;
                    res.status = StNotStem;
                  end
                end else if (leaf_hit) begin
                  if (rest == '0) begin
                    res_valid  = 1'b1;
                    res.status = StEmpty;
                  end else begin
                    phase_d = PhPayload;
                    left_d  = rest;
                  end
                end else if (rest == '0) begin
                  phase_d = PhHeader;
                  cnt_d   = 3'd0;
                  if (has_parent && (new_top == '0)) begin
                    res_valid  = 1'b1;
                    res.status = StNotStem;
                  end
                end else begin
                  phase_d = PhSkip;
                  left_d  = rest;
                end
              end
            end
          end
          PhSkip: begin
            left_d = left_nx;
            if (left_nx == '0) begin
              phase_d = PhHeader;
              cnt_d   = 3'd0;
              if (cur_empty) begin
                res_valid  = 1'b1;
                res.status = StNotStem;
              end
            end
          end
          PhPayload: begin
            left_d           = left_nx;
            res_valid        = 1'b1;
            res.payload_byte = item_i.data_byte;
            res.last_of_run  = (left_nx == '0);
          end
          default: begin
            phase_d = PhHeader;
          end
        endcase

        if (item_i.final_byte) begin
          next_empty = (depth_d != 2'd0) && (budget_d[depth_d[1]] == '0);
          if (!res_valid) begin
            res_valid = 1'b1;
            if (phase_d == PhExt) begin
              res.status = StTruncExt;
            end else if ((phase_d == PhSkip) && next_empty) begin
              res.status = StNotStem;
            end else begin
              res.status = StTruncHdr;
            end
          end else if ((res.status == StPayload) && !res.last_of_run) begin
            res.status       = StTruncPay;
            res.payload_byte = 8'd0;
          end
        end

        if (res_valid && ((res.status != StPayload) || res.last_of_run)) begin
          done_d = 1'b1;
        end
      end

      if (res.status != StPayload) begin
        res.last_of_run = 1'b1;
      end

      if (item_i.final_byte) begin
        phase_d = PhHeader;
        cnt_d   = 3'd0;
        depth_d = 2'd0;
        done_d  = 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      cnt_q   <= 3'd0;
      depth_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      depth_q <= depth_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q     <= shift_d;
    type_q      <= type_d;
    left_q      <= left_d;
    budget_q[0] <= budget_d[0];
    budget_q[1] <= budget_d[1];
  end

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q != 2'd3)
    else $error("open depth out of range");

  a_payload_at_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (depth_q == 2'd2))
    else $error("payload phase outside the leaf level");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && item_i.final_byte) |=>
      (phase_q == PhHeader && depth_q == 2'd0 && !done_q && cnt_q == 3'd0))
    else $error("final byte did not return the parser to its start");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !res_valid)
    else $error("result after the outcome of the file");
`endif

endmodule

// ===== sv/nested_box_path_extractor.sv =====
`timescale 1ns / 1ps

// Channel | Handshake                 | Payload
// --------+---------------------------+-----------------------------------------
// in      | in_valid_i / in_ready_o   | in_data_i   : data_byte, final_byte
// out     | out_valid_o / out_ready_i | out_data_o  : payload_byte, status, last
// cfg     | cfg_we_i (no wait)        | cfg_index_i, cfg_wdata_i (box types)
//
// One byte per clock unless the result side stalls; a taken request waits in the
// input register and passes the combinational parse logic into the result register.
// A 64-bit budget subtract and size compare against the open parent set the cycle.
// Reset clears the parser state and loads the default box types; there is
// no clearing pass. A stalled result only holds back the input register:
// in_ready_o stays high while the input register is empty or can move on.

module nested_box_path_extractor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  nbpe_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output nbpe_pkg::out_item_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [nbpe_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [nbpe_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);
  import nbpe_pkg::*;

  // Box type registers
  box_cfg_t  cfg_q, cfg_d;

  // Input register
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;

  // Result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic      go;
  logic      res_valid;
  out_item_t res;

  // Advance the held request whenever the result slot is free or being drained
  assign go         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || go;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgOuter:  cfg_d.outer_box_type  = cfg_wdata_i;
        CfgMiddle: cfg_d.middle_box_type = cfg_wdata_i;
        CfgLeaf:   cfg_d.leaf_box_type   = cfg_wdata_i;
        default: begin
          // Drop writes beyond the register list
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  nbpe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .item_i      (in_item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_box_type  <= OuterTypeReset;
      cfg_q.middle_box_type <= MiddleTypeReset;
      cfg_q.leaf_box_type   <= LeafTypeReset;
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on a taken request or a fresh result
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

`ifndef ASSERT_OFF
  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StPayload || out_data_o.last_of_run))
    else $error("outcome status without end of run");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StPayload) |-> (out_data_o.payload_byte == 8'd0))
    else $error("outcome status carries a payload byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result produced while the result register is full");

  a_input_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> go)
    else $error("held request did not advance into a free result slot");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Byte-stream checks for the nested box path extractor. Files are fed one
// request per byte; every accepted request runs through a local mirror of
// the parser and whatever result it yields is queued and compared in order.
module testbench;
  import nbpe_pkg::*;

  // Input register plus parse stage, with margin
  localparam int unsigned PipeDepth  = 4;
  // Cycles without any handshake before the run is declared hung
  localparam int unsigned StallLimit = 1000;
  // A plain box type that none of the default selections use
  localparam logic [31:0] FreeType   = 32'h66726565;

  logic clk = 1'b0;
  logic rst_n;

  logic                    in_valid;
  logic                    in_ready;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  out_item_t               out_data;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_wdata;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // Mirror of the box selections last written to the block
  logic [31:0] outer_sel;
  logic [31:0] middle_sel;
  logic [31:0] leaf_sel;

  // Mirror of the parser state
  phase_e      ph;
  logic [4:0]  hdr_cnt;
  size_t       hdr_shift;
  logic [31:0] seen_type;
  logic [1:0]  depth;
  size_t       budget [2];
  size_t       left;
  logic        done;

  // Results the parser still owes, oldest first
  out_item_t   expected_q [$];

  // File under construction, sent front to back
  logic [7:0]  file_bytes [$];
  int unsigned skip_cnt [6];
  int unsigned skip_len [6][3];
  bit          skip_ext [6][3];

  nested_box_path_extractor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random; the rate follows the current regime.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every taken result with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: payload_byte %0h status %0d last_of_run %0b",
               out_data.payload_byte, out_data.status, out_data.last_of_run);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, actual %0h",
                 want.payload_byte, out_data.payload_byte);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 want.last_of_run, out_data.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------

  task automatic clear_parser();
    ph        = PhHeader;
    hdr_cnt   = '0;
    hdr_shift = '0;
    seen_type = '0;
    depth     = '0;
    budget[0] = '0;
    budget[1] = '0;
    left      = '0;
    done      = 1'b0;
  endtask

  // Any outcome other than a mid-run payload byte ends the file.
  task automatic give_result(input logic [7:0] b, input status_e st, input logic last,
                             output bit got, output out_item_t r);
    r.payload_byte = b;
    r.status       = st;
    r.last_of_run  = last;
    got            = 1'b1;
    if (st != StPayload || last) done = 1'b1;
  endtask

  function automatic bit parent_spent();
    return depth != 2'd0 && budget[1'(depth - 2'd1)] == '0;
  endfunction

  // Start a new header; an open parent with nothing left cannot hold it.
  task automatic next_header(output bit got, output out_item_t r);
    got       = 1'b0;
    r         = '0;
    ph        = PhHeader;
    hdr_cnt   = '0;
    hdr_shift = '0;
    if (parent_spent()) give_result(8'd0, StNotStem, 1'b1, got, r);
  endtask

  // Decide what to do with a box once its full header is in.
  task automatic handle_box(input size_t box_size, input size_t hdr_len,
                            output bit got, output out_item_t r);
    size_t rest;
    got = 1'b0;
    r   = '0;
    if (box_size < hdr_len) begin
      // Short box: smaller than its own header
      give_result(8'd0, StNotStem, 1'b1, got, r);
    end else if (depth != 2'd0 && box_size > budget[1'(depth - 2'd1)]) begin
      // Child overrun: larger than what the parent has left
      give_result(8'd0, StNotStem, 1'b1, got, r);
    end else begin
      if (depth != 2'd0) begin
        budget[1'(depth - 2'd1)] = budget[1'(depth - 2'd1)] - box_size;
      end
      rest = box_size - hdr_len;
      if ((depth == 2'd0 && seen_type == outer_sel) ||
          (depth == 2'd1 && seen_type == middle_sel)) begin
        // Descend: the box body becomes the new innermost budget
        budget[depth[0]] = rest;
        depth            = depth + 2'd1;
        next_header(got, r);
      end else if (depth == 2'd2 && seen_type == leaf_sel) begin
        if (rest == '0) begin
          give_result(8'd0, StEmpty, 1'b1, got, r);
        end else begin
          ph   = PhPayload;
          left = rest;
        end
      end else if (rest == '0) begin
        next_header(got, r);
      end else begin
        ph   = PhSkip;
        left = rest;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, output bit got, output out_item_t r);
    got = 1'b0;
    r   = '0;
    case (ph)
      PhHeader: begin
        hdr_shift = {hdr_shift[55:0], b};
        hdr_cnt   = hdr_cnt + 5'd1;
        if (hdr_cnt == 5'd8) begin
          seen_type = hdr_shift[31:0];
          if (hdr_shift[63:32] == ExtSizeMark) begin
            ph        = PhExt;
            hdr_cnt   = '0;
            hdr_shift = '0;
          end else begin
            handle_box({32'd0, hdr_shift[63:32]}, HdrLenShort, got, r);
          end
        end
      end
      PhExt: begin
        hdr_shift = {hdr_shift[55:0], b};
        hdr_cnt   = hdr_cnt + 5'd1;
        if (hdr_cnt == 5'd8) handle_box(hdr_shift, HdrLenLong, got, r);
      end
      PhSkip: begin
        left = left - 1;
        if (left == '0) next_header(got, r);
      end
      default: begin
        left = left - 1;
        give_result(b, StPayload, left == '0, got, r);
      end
    endcase
  endtask

  // Advance the mirror by one accepted request and queue what it owes.
  task automatic predict_byte(input in_item_t it);
    bit        got;
    out_item_t r;
    got = 1'b0;
    r   = '0;
    bytes_sent++;
    if (done) begin
      // Drop everything after an outcome until the file ends
      if (it.final_byte) clear_parser();
    end else begin
      take_byte(it.data_byte, got, r);
      if (it.final_byte) begin
        if (!got) begin
          if (ph == PhExt) begin
            give_result(8'd0, StTruncExt, 1'b1, got, r);
          end else if (ph == PhSkip && parent_spent()) begin
            give_result(8'd0, StNotStem, 1'b1, got, r);
          end else begin
            give_result(8'd0, StTruncHdr, 1'b1, got, r);
          end
        end else if (r.status == StPayload && !r.last_of_run) begin
          // File ends inside the leaf payload
          give_result(8'd0, StTruncPay, 1'b1, got, r);
        end
        clear_parser();
      end
      if (got) expected_q.insert(expected_q.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Hold the request until it is taken, then feed it to the mirror.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.data_byte  = b;
    it.final_byte = fin;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_byte(it);
  endtask

  // Drop the request line and wait for every owed result.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Send the file under construction; optionally drain before one byte.
  task automatic send_file(input int pause_at);
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i == pause_at) drain_results();
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Change the box selections only with the parser idle.
  task automatic set_box_types(input logic [31:0] o, input logic [31:0] m,
                               input logic [31:0] l);
    drain_results();
    repeat (PipeDepth) @(posedge clk);
    write_reg(CfgOuter, o);
    write_reg(CfgMiddle, m);
    write_reg(CfgLeaf, l);
    @(negedge clk);
    cfg_we     <= 1'b0;
    outer_sel  = o;
    middle_sel = m;
    leaf_sel   = l;
  endtask

  // ---------------------------------------------------------------------
  // File building
  // ---------------------------------------------------------------------

  task automatic append_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic put_hdr(input size_t box_size, input logic [31:0] kind, input bit ext);
    logic [31:0] head;
    head = ext ? ExtSizeMark : box_size[31:0];
    for (int i = 3; i >= 0; i--) append_byte(head[8*i +: 8]);
    for (int i = 3; i >= 0; i--) append_byte(kind[8*i +: 8]);
    if (ext) begin
      for (int i = 7; i >= 0; i--) append_byte(box_size[8*i +: 8]);
    end
  endtask

  task automatic put_fill(input int unsigned n);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_file(input int unsigned n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  function automatic logic [31:0] other_type(input logic [31:0] avoid);
    logic [31:0] v;
    v = $urandom;
    if (v == avoid) v = ~avoid;
    return v;
  endfunction

  // Emit one group of sibling boxes that the parser has to skip.
  task automatic put_group(input int g);
    logic [31:0] avoid;
    avoid = (g == 0 || g == 5) ? outer_sel : (g == 1 || g == 4) ? middle_sel : leaf_sel;
    for (int k = 0; k < skip_cnt[g]; k++) begin
      put_hdr(size_t'((skip_ext[g][k] ? 16 : 8) + skip_len[g][k]), other_type(avoid),
              skip_ext[g][k]);
      put_fill(skip_len[g][k]);
    end
  endtask

  // Mostly well-formed outer/middle/leaf nests with random siblings, some
  // of them cut short, bit-flipped or padded; a few files are pure noise.
  task automatic build_random_file();
    int unsigned grp [6];
    int unsigned leaf_len;
    int unsigned mut;
    int unsigned pos;
    bit          ox;
    bit          mx;
    bit          lx;
    size_t       leaf_sz;
    size_t       mid_sz;
    size_t       out_sz;
    file_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      put_fill($urandom_range(1, 24));
    end else begin
      for (int g = 0; g < 6; g++) begin
        skip_cnt[g] = $urandom_range(0, (g < 3) ? 2 : 1);
        grp[g]      = 0;
        for (int k = 0; k < skip_cnt[g]; k++) begin
          skip_len[g][k] = $urandom_range(0, 5);
          skip_ext[g][k] = ($urandom_range(0, 7) == 0);
          grp[g] += (skip_ext[g][k] ? 16 : 8) + skip_len[g][k];
        end
      end
      leaf_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
      ox       = ($urandom_range(0, 5) == 0);
      mx       = ($urandom_range(0, 5) == 0);
      lx       = ($urandom_range(0, 5) == 0);
      leaf_sz  = size_t'((lx ? 16 : 8) + leaf_len);
      mid_sz   = size_t'((mx ? 16 : 8) + grp[2] + grp[3]) + leaf_sz;
      out_sz   = size_t'((ox ? 16 : 8) + grp[1] + grp[4]) + mid_sz;
      put_group(0);
      put_hdr(out_sz, outer_sel, ox);
      put_group(1);
      put_hdr(mid_sz, middle_sel, mx);
      put_group(2);
      // Now and then hide the leaf so the middle box runs dry
      put_hdr(leaf_sz, ($urandom_range(0, 7) != 0) ? leaf_sel : other_type(leaf_sel), lx);
      put_fill(leaf_len);
      put_group(3);
      put_group(4);
      put_group(5);
      mut = $urandom_range(0, 9);
      if (mut == 0) begin
        trim_file($urandom_range(1, file_bytes.size()));
      end else if (mut == 1) begin
        pos = $urandom_range(0, file_bytes.size() - 1);
        file_bytes[pos] = file_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
      end else if (mut == 2) begin
        put_fill($urandom_range(1, 5));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Leaf payload with both byte extremes; drain in the middle of it.
  task automatic test_found_payload();
    file_bytes.delete();
    put_hdr(size_t'(27), outer_sel, 1'b0);
    put_hdr(size_t'(19), middle_sel, 1'b0);
    put_hdr(size_t'(11), leaf_sel, 1'b0);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'hA5);
    send_file(25);
  endtask

  // Zero-length leaf after a skipped sibling, then bytes that must be dropped.
  task automatic test_empty_leaf_then_ignored();
    file_bytes.delete();
    put_hdr(size_t'(32), outer_sel, 1'b0);
    put_hdr(size_t'(24), middle_sel, 1'b0);
    put_hdr(size_t'(8), FreeType, 1'b0);
    put_hdr(size_t'(8), leaf_sel, 1'b0);
    put_fill(3);
    send_file(-1);
  endtask

  // Extended sizes on a skipped box, the outer box and the leaf.
  task automatic test_extended_size();
    file_bytes.delete();
    put_hdr(size_t'(17), FreeType, 1'b1);
    put_fill(1);
    put_hdr(size_t'(42), outer_sel, 1'b1);
    put_hdr(size_t'(26), middle_sel, 1'b0);
    put_hdr(size_t'(18), leaf_sel, 1'b1);
    put_fill(2);
    send_file(-1);
  endtask

  // Boxes smaller than their header, size zero included.
  task automatic test_short_box();
    file_bytes.delete();
    put_hdr(size_t'(0), FreeType, 1'b0);
    put_fill(1);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(7), FreeType, 1'b0);
    put_fill(1);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(15), FreeType, 1'b1);
    put_fill(1);
    send_file(-1);
  endtask

  // Children claiming more than the parent has, up to the widest size.
  task automatic test_child_overrun();
    file_bytes.delete();
    put_hdr(size_t'(24), outer_sel, 1'b0);
    put_hdr(size_t'(28), middle_sel, 1'b0);
    put_fill(2);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(24), outer_sel, 1'b0);
    put_hdr('1, FreeType, 1'b1);
    put_fill(1);
    send_file(-1);
  endtask

  // Parent budget at zero: on entry, at the next header, and at file end.
  task automatic test_exhausted_parent();
    file_bytes.delete();
    put_hdr(size_t'(8), outer_sel, 1'b0);
    put_fill(1);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(20), outer_sel, 1'b0);
    put_hdr(size_t'(12), FreeType, 1'b0);
    put_fill(5);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(20), outer_sel, 1'b0);
    put_hdr(size_t'(12), FreeType, 1'b0);
    put_fill(2);
    send_file(-1);
  endtask

  // File ends in each phase: header, extended size, payload and skip.
  task automatic test_file_end();
    file_bytes.delete();
    put_hdr(size_t'(12), FreeType, 1'b0);
    trim_file(5);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(16), FreeType, 1'b1);
    trim_file(11);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(28), outer_sel, 1'b0);
    put_hdr(size_t'(20), middle_sel, 1'b0);
    put_hdr(size_t'(12), leaf_sel, 1'b0);
    put_fill(2);
    send_file(-1);
    file_bytes.delete();
    put_hdr(size_t'(12), FreeType, 1'b0);
    put_fill(2);
    send_file(-1);
    file_bytes.delete();
    put_hdr('1, FreeType, 1'b1);
    put_fill(3);
    send_file(-1);
  endtask

  // Extreme and random box selections, one file under each.
  task automatic test_box_types();
    set_box_types(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    build_random_file();
    send_file(-1);
    set_box_types(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    build_random_file();
    send_file(-1);
    set_box_types($urandom, $urandom, $urandom);
    build_random_file();
    send_file(-1);
  endtask

  // Random files under one idle regime, reselecting box types now and then.
  task automatic test_random_files(input int unsigned sender_idle,
                                   input int unsigned recv_stall,
                                   input int unsigned n_bytes);
    int unsigned goal;
    send_idle_pct  = sender_idle;
    recv_stall_pct = recv_stall;
    goal           = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          set_box_types(OuterTypeReset, MiddleTypeReset, LeafTypeReset);
        end else begin
          set_box_types($urandom, $urandom, $urandom);
        end
      end
      build_random_file();
      send_file(-1);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CfgOuter;
    cfg_wdata      = '0;
    send_idle_pct  = 17;
    recv_stall_pct = 45;
    bytes_sent     = 0;
    mismatch_count = 0;
    outer_sel      = OuterTypeReset;
    middle_sel     = MiddleTypeReset;
    leaf_sel       = LeafTypeReset;
    clear_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed files run on the reset box selections
    test_found_payload();
    test_empty_leaf_then_ignored();
    test_extended_size();
    test_short_box();
    test_child_overrun();
    test_exhausted_parent();
    test_file_end();
    test_box_types();

    test_random_files(17, 45, 170);
    test_random_files(45, 17, 170);
    test_random_files(0, 0, 170);

    drain_results();
    repeat (2 * PipeDepth) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
